/* rtl/ordered_list_engine_defines.svh */
// Assertion macros shared by the ordered list engine RTL.
// Depends on nothing; included by files that carry assertions.
`ifndef ORDERED_LIST_ENGINE_DEFINES_SVH
`define ORDERED_LIST_ENGINE_DEFINES_SVH

// Implication checked on every clock edge outside of reset.
`define OLE_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked on the clock edge after the antecedent.
`define OLE_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/ole_pkg.sv */
// Package for the ordered list engine: operation codes, payload structs.
// Depends on nothing.
package ole_pkg;

  localparam int CAPACITY_DEF    = 16;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int POS_W           = 8;
  localparam int ITEM_W          = 32;
  localparam int CNT_W           = 5;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_GET    = 2'd3
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [POS_W-1:0]  position;
    logic [ITEM_W-1:0] item_value;
  } in_item_t;

  typedef struct packed {
    logic [ITEM_W-1:0] read_value;
    logic              hit;
    logic              accepted;
    logic [CNT_W-1:0]  entry_count;
  } out_item_t;

endpackage

/* rtl/ole_ram.sv */
// Generic single-port-write, one-read RAM with registered read data.
// Depends on nothing.
module ole_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/ordered_list_engine.sv */
// Top level of the ordered list engine: sequencer around one list RAM.
// Depends on ole_pkg, ole_ram and ordered_list_engine_defines.svh.
//
//  Channel  Ports                       Handshake
//  input    in_item                     start high while busy low
//  result   out_item                    out_valid strobe, one cycle
//
// Append, insert at the tail, full list, empty remove, get out of range: straight
// from decide to done. Get in range: one read in the scan state. Insert inside:
// shift entries up from the tail, then write the gap. Remove: scan from the head,
// and on a hit shift each later entry down; a shift needs a read and a write.
// Busy falls in the cycle after the result, so the next start is taken then.
// Reset clears the count; list contents are undefined until written.
// The receiver cannot stall: the result stands for one cycle only.
`include "ordered_list_engine_defines.svh"

module ordered_list_engine
  import ole_pkg::*;
#(
  parameter int CAPACITY    = CAPACITY_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_DECIDE = 7'b0000010,
    ST_SCAN   = 7'b0000100,
    ST_SHRD   = 7'b0001000,
    ST_SHWR   = 7'b0010000,
    ST_PUT    = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_t;

  state_t                 state_r, state_nxt;
  op_t                    op_r, op_nxt;
  logic [POS_W-1:0]       pos_r, pos_nxt;
  logic [VALUE_WIDTH-1:0] val_r, val_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [CW-1:0]          idx_r, idx_nxt;
  logic                   hit_r, hit_nxt;
  logic                   acc_r, acc_nxt;
  logic [VALUE_WIDTH-1:0] rdv_r, rdv_nxt;
  logic                   pos_in_range;

  logic                   we;
  logic [AW-1:0]          waddr, raddr;
  logic [VALUE_WIDTH-1:0] wdata, rdata;

  ole_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // The position names a stored entry.
  assign pos_in_range = (32'(pos_r) < 32'(cnt_r));

  // Sequencer: scans, shifts and writes one entry at a time. No read data that it
  // uses comes from an entry written in the same cycle, so the RAM needs no forwarding.
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    pos_nxt   = pos_r;
    val_nxt   = val_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    hit_nxt   = hit_r;
    acc_nxt   = acc_r;
    rdv_nxt   = rdv_r;
    we        = 1'b0;
    waddr     = AW'(idx_r);
    wdata     = val_r;
    raddr     = AW'(idx_r);
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          op_nxt    = in_item.op;
          pos_nxt   = in_item.position;
          val_nxt   = VALUE_WIDTH'(in_item.item_value);
          hit_nxt   = 1'b0;
          acc_nxt   = 1'b0;
          rdv_nxt   = '0;
          idx_nxt   = '0;
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        // Decide the first step of the operation.
        state_nxt = ST_DONE;
        case (op_r)
          OP_APPEND, OP_INSERT: begin
            if (cnt_r < CW'(CAPACITY)) begin
              acc_nxt = 1'b1;
              if (op_r == OP_INSERT && pos_in_range) begin
                // Shift from the tail down to the insert position.
                idx_nxt   = cnt_r;
                state_nxt = ST_SHRD;
              end else begin
                we      = 1'b1;
                waddr   = AW'(cnt_r);
                cnt_nxt = cnt_r + 1'b1;
              end
            end
          end
          OP_REMOVE: begin
            if (cnt_r != '0) begin
              raddr     = '0;
              idx_nxt   = '0;
              state_nxt = ST_SCAN;
            end
          end
          OP_GET: begin
            if (pos_in_range) begin
              raddr     = AW'(pos_r);
              state_nxt = ST_SCAN;
            end
          end
          default: state_nxt = ST_DONE;
        endcase
      end
      ST_SCAN: begin
        // RAM data for the entry read last cycle is valid here.
        if (op_r == OP_GET) begin
          hit_nxt   = 1'b1;
          rdv_nxt   = rdata;
          state_nxt = ST_DONE;
        end else if (rdata == val_r) begin
          hit_nxt = 1'b1;
          if (idx_r + 1'b1 < cnt_r) begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = ST_SHRD;
          end else begin
            cnt_nxt   = cnt_r - 1'b1;
            state_nxt = ST_DONE;
          end
        end else if (idx_r + 1'b1 < cnt_r) begin
          idx_nxt = idx_r + 1'b1;
          raddr   = AW'(idx_r + 1'b1);
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_SHRD: begin
        // Read the source entry of one shift step.
        if (op_r == OP_INSERT) begin
          raddr = AW'(idx_r - 1'b1);
        end
        state_nxt = ST_SHWR;
      end
      ST_SHWR: begin
        we    = 1'b1;
        wdata = rdata;
        if (op_r == OP_INSERT) begin
          // Insert: move entry idx_r-1 up to idx_r.
          waddr = AW'(idx_r);
          if ((idx_r - 1'b1) == CW'(pos_r)) begin
            state_nxt = ST_PUT;
          end else begin
            idx_nxt   = idx_r - 1'b1;
            state_nxt = ST_SHRD;
          end
        end else begin
          // Remove: move entry idx_r down one place.
          waddr = AW'(idx_r - 1'b1);
          if (idx_r + 1'b1 < cnt_r) begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = ST_SHRD;
          end else begin
            cnt_nxt   = cnt_r - 1'b1;
            state_nxt = ST_DONE;
          end
        end
      end
      ST_PUT: begin
        // Final write of an insert into the opened gap.
        we        = 1'b1;
        waddr     = AW'(pos_r);
        wdata     = val_r;
        cnt_nxt   = cnt_r + 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Operand and result registers.
  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    pos_r <= pos_nxt;
    val_r <= val_nxt;
    idx_r <= idx_nxt;
    hit_r <= hit_nxt;
    acc_r <= acc_nxt;
    rdv_r <= rdv_nxt;
  end

  // Result transaction.
  assign busy      = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_DONE);
  always_comb begin
    out_item             = '0;
    out_item.read_value  = ITEM_W'(rdv_r);
    out_item.hit         = hit_r;
    out_item.accepted    = acc_r;
    out_item.entry_count = CNT_W'(cnt_r);
  end

  `OLE_ASSERT_IMP(a_cnt_max, clk, rst_n, 1'b1, cnt_r <= CW'(CAPACITY), "count above capacity")
  `OLE_ASSERT_NXT(a_one_strobe, clk, rst_n, out_valid, !out_valid, "result held twice")
  `OLE_ASSERT_IMP(a_busy_out, clk, rst_n, out_valid, busy, "result while idle")
  `OLE_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accepted but not busy")

endmodule

/* tb/tb_ordered_list_engine.sv */
// Self-checking testbench for the ordered list engine: directed table, then random traffic.
// Depends on ole_pkg and the ordered_list_engine RTL.
`timescale 1ns / 100ps

module tb_ordered_list_engine;
  import ole_pkg::*;

  localparam int CAP       = 16;
  localparam int N_RANDOM  = 1600;
  localparam int MAX_CYCLE = 400000;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;

  ordered_list_engine dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // Shadow copy of the list, updated for each accepted transaction.
  logic [31:0] list_vals[CAP];
  int          list_len;
  out_item_t   pending_results[$];
  bit          failed;
  int          cycle_cnt;

  function automatic out_item_t apply_list_op(in_item_t it);
    out_item_t r;
    int at;
    int k;
    int j;
    r = '0;
    if (it.op == OP_APPEND || it.op == OP_INSERT) begin
      if (list_len < CAP) begin
        at = list_len;
        if (it.op == OP_INSERT && it.position < list_len) at = it.position;
        for (k = list_len; k > at; k--) list_vals[k] = list_vals[k-1];
        list_vals[at] = it.item_value;
        list_len++;
        r.accepted = 1'b1;
      end
    end else if (it.op == OP_REMOVE) begin
      for (k = 0; k < list_len; k++) begin
        if (list_vals[k] == it.item_value) begin
          for (j = k; j + 1 < list_len; j++) list_vals[j] = list_vals[j+1];
          list_len--;
          r.hit = 1'b1;
          break;
        end
      end
    end else begin
      if (it.position < list_len) begin
        r.read_value = list_vals[it.position];
        r.hit = 1'b1;
      end
    end
    r.entry_count = list_len[4:0];
    return r;
  endfunction

  // Result checker: every strobe is compared with the oldest expectation.
  always @(posedge clk) begin
    out_item_t exp_r;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_item);
        failed = 1'b1;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_item.read_value !== exp_r.read_value)
          $display("%0t: read_value expected %h actual %h", $time,
                   exp_r.read_value, out_item.read_value);
        if (out_item.hit !== exp_r.hit)
          $display("%0t: hit expected %b actual %b", $time, exp_r.hit, out_item.hit);
        if (out_item.accepted !== exp_r.accepted)
          $display("%0t: accepted expected %b actual %b", $time,
                   exp_r.accepted, out_item.accepted);
        if (out_item.entry_count !== exp_r.entry_count)
          $display("%0t: entry_count expected %0d actual %0d", $time,
                   exp_r.entry_count, out_item.entry_count);
        if (out_item !== exp_r) failed = 1'b1;
      end
    end
  end

  // Timeout watchdog.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == MAX_CYCLE) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Directed rows: op, position, value, and a typed expectation where obvious.
  typedef struct {
    op_t         op;
    logic [7:0]  pos;
    logic [31:0] val;
    bit          has_exp;
    out_item_t   exp_r;
  } dir_row_t;

  dir_row_t dir_rows[$];
  logic [31:0] used_vals[$];
  bit          quiet;

  // Drives one transaction and waits until the block accepts it.
  task automatic send_item(in_item_t it, bit has_exp, out_item_t typed);
    out_item_t p;
    if (!quiet && $urandom_range(99) < 30) begin
      start <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    p = apply_list_op(it);
    if (has_exp && p !== typed) begin
      $display("%0t: table row expected %p, predictor gives %p", $time, typed, p);
      failed = 1'b1;
    end
    pending_results.push_back(p);
    if (it.op != OP_GET && it.op != OP_REMOVE) used_vals.push_back(it.item_value);
  endtask

  function automatic out_item_t mk(logic [31:0] rv, bit h, bit a, int c);
    out_item_t r;
    r.read_value = rv; r.hit = h; r.accepted = a; r.entry_count = c[4:0];
    return r;
  endfunction

  function automatic dir_row_t row(op_t o, logic [7:0] p, logic [31:0] v,
                                   bit he, out_item_t e);
    dir_row_t d;
    d.op = o; d.pos = p; d.val = v; d.has_exp = he; d.exp_r = e;
    return d;
  endfunction

  initial begin
    in_item_t it;
    int n;
    int k;
    failed    = 1'b0;
    cycle_cnt = 0;
    list_len  = 0;
    quiet     = 1'b0;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_item   = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty list: get and remove miss, then extremes of value and position.
    dir_rows.push_back(row(OP_GET, 8'd0, 32'h0, 1, mk(0, 0, 0, 0)));
    dir_rows.push_back(row(OP_REMOVE, 8'd0, 32'h0, 1, mk(0, 0, 0, 0)));
    dir_rows.push_back(row(OP_APPEND, 8'd0, 32'hFFFF_FFFF, 1, mk(0, 0, 1, 1)));
    dir_rows.push_back(row(OP_GET, 8'd0, 32'h0, 1, mk(32'hFFFF_FFFF, 1, 0, 1)));
    dir_rows.push_back(row(OP_INSERT, 8'd255, 32'h0, 1, mk(0, 0, 1, 2)));
    dir_rows.push_back(row(OP_INSERT, 8'd0, 32'h1234_5678, 1, mk(0, 0, 1, 3)));
    dir_rows.push_back(row(OP_GET, 8'd255, 32'hFFFF_FFFF, 1, mk(0, 0, 0, 3)));
    dir_rows.push_back(row(OP_APPEND, 8'hAA, 32'h1234_5678, 0, '0));
    dir_rows.push_back(row(OP_REMOVE, 8'd0, 32'h1234_5678, 0, '0));
    dir_rows.push_back(row(OP_GET, 8'd2, 32'h0, 0, '0));
    dir_rows.push_back(row(OP_REMOVE, 8'd0, 32'h5555_5555, 0, '0));
    foreach (dir_rows[i]) begin
      it.op = dir_rows[i].op; it.position = dir_rows[i].pos;
      it.item_value = dir_rows[i].val;
      send_item(it, dir_rows[i].has_exp, dir_rows[i].exp_r);
    end
    // Fill to capacity, show that append and insert are dropped, then get the last entry and one past it.
    while (list_len < CAP) begin
      it.op = OP_INSERT; it.position = 8'd1; it.item_value = $urandom;
      send_item(it, 0, '0);
    end
    it.op = OP_APPEND; it.position = 8'd0; it.item_value = 32'h0;
    send_item(it, 1, mk(0, 0, 0, CAP));
    it.op = OP_INSERT;
    send_item(it, 1, mk(0, 0, 0, CAP));
    it.op = OP_GET; it.position = 8'd15;
    send_item(it, 0, '0);
    it.position = 8'd16;
    send_item(it, 1, mk(0, 0, 0, CAP));

    // Random traffic: removes mostly target values sent by earlier appends and inserts, a long quiet stretch.
    for (n = 0; n < N_RANDOM; n++) begin
      quiet = (n >= 600 && n < 900);
      it.op = op_t'($urandom_range(3));
      it.position = ($urandom_range(3) == 0) ? 8'($urandom)
                                             : 8'($urandom_range(CAP));
      it.item_value = $urandom;
      if ($urandom_range(3) == 0) it.item_value = 32'($urandom_range(3));
      if (it.op == OP_REMOVE && used_vals.size() > 0 && $urandom_range(3) != 0) begin
        k = $urandom_range(used_vals.size() - 1);
        it.item_value = used_vals[k];
      end
      if (used_vals.size() > 64) void'(used_vals.pop_front());
      send_item(it, 0, '0);
    end
    start <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (!failed) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/ole_pkg.sv
rtl/ole_ram.sv
rtl/ordered_list_engine.sv
tb/tb_ordered_list_engine.sv
